### hw/rtl/pls_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg: shared types for the positional list store
// Operation and status codes, and the per-cell shift command.
// ----------------------------------------------------------------------------
package pls_pkg;

  // operation codes carried on the op field
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_APPEND = 3'd1,
    OP_DELETE = 3'd2,
    OP_WRITE  = 3'd3,
    OP_READ   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // what one cell loads at the next clock edge
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_NEW   = 2'd1,
    CELL_TAKE_LEFT  = 2'd2,
    CELL_TAKE_RIGHT = 2'd3
  } cell_cmd_t;

endpackage

### hw/rtl/positional_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store: fixed-capacity ordered list addressed by position
// A row of cells holds the list; insert and delete move every later entry
// one place, with all cells loading in parallel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries op, position and value.
//   Output channel (out_valid / out_stall) carries status, read_value and
//   length; every input transfer yields exactly one output transfer.
//   The result is registered at the edge that takes the item. Throughput is
//   one item per cycle unless the receiver stalls; cells load in parallel
//   and the read mux and count update are combinational.
//   A rejected operation leaves the list and the length unchanged.
//   Reset empties the list (length zero) and drops any waiting result by
//   clearing out_valid; the result fields themselves are not cleared.
//   Cell contents are not cleared, and positions past the length are never
//   read.
//   While the receiver stalls a waiting result, in_stall is raised and the
//   result holds; a new item is taken in the same cycle the old result
//   leaves.
// ----------------------------------------------------------------------------
module positional_list_store #(
  parameter int CAPACITY   = 32,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic [5:0]  position,
  input  logic [31:0] value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] read_value,
  output logic [5:0]  length
);
  import pls_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int PW = ((CW > 6) ? CW : 6) + 1;

  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic                  accept;
  logic [PW-1:0]         pos_x;
  logic [PW-1:0]         cnt_x;
  logic [PW-1:0]         idx;
  logic [63:0]           val64;
  logic [ELEM_WIDTH-1:0] new_val;
  logic [63:0]           rd64;
  logic                  do_insert;
  logic                  do_load;
  logic                  do_delete;
  logic                  do_read;
  status_t               st;

  logic [ELEM_WIDTH-1:0] cell_val [CAPACITY];

  status_t               status_r;
  logic [31:0]           read_value_r;

  // input transfer when the output register is free or being emptied
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_x   = PW'(position);
  assign cnt_x   = PW'(count);
  assign val64   = 64'(value);
  assign new_val = val64[ELEM_WIDTH-1:0];

  // operation decode and status
  always_comb begin
    st        = ST_OK;
    do_insert = 1'b0;
    do_load   = 1'b0;
    do_delete = 1'b0;
    do_read   = 1'b0;
    idx       = pos_x - PW'(1);
    case (op_t'(op))
      OP_INSERT: begin
        if (count == CW'(CAPACITY)) begin
          st = ST_FULL;
        end else if (position == 6'd0 || pos_x > cnt_x + PW'(1)) begin
          st = ST_BADPOS;
        end else begin
          do_insert = 1'b1;
        end
      end
      OP_APPEND: begin
        idx = cnt_x;
        if (count == CW'(CAPACITY)) begin
          st = ST_FULL;
        end else begin
          do_load = 1'b1;
        end
      end
      OP_DELETE, OP_WRITE, OP_READ: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else if (position == 6'd0 || pos_x > cnt_x) begin
          st = ST_BADPOS;
        end else if (op_t'(op) == OP_DELETE) begin
          do_delete = 1'b1;
        end else if (op_t'(op) == OP_WRITE) begin
          do_load = 1'b1;
        end else begin
          do_read = 1'b1;
        end
      end
      default: st = ST_OK;
    endcase
  end

  // length update
  always_comb begin
    count_next = count;
    if (accept && (do_insert || (do_load && op_t'(op) == OP_APPEND))) begin
      count_next = count + CW'(1);
    end else if (accept && do_delete) begin
      count_next = count - CW'(1);
    end
  end

  // read port over the cell chain
  assign rd64 = do_read ? 64'(cell_val[idx[IW-1:0]]) : 64'd0;

  // cell chain with per-cell shift commands
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_cmd_t             cmd;
    logic [ELEM_WIDTH-1:0] left_val;
    logic [ELEM_WIDTH-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = new_val;
    end else begin : g_left
      assign left_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = cell_val[i];
    end else begin : g_right
      assign right_val = cell_val[i+1];
    end

    always_comb begin
      cmd = CELL_HOLD;
      if (accept) begin
        if (do_insert && PW'(i) > idx) begin
          cmd = CELL_TAKE_LEFT;
        end else if ((do_insert || do_load) && PW'(i) == idx) begin
          cmd = CELL_LOAD_NEW;
        end else if (do_delete && PW'(i) >= idx) begin
          cmd = CELL_TAKE_RIGHT;
        end
      end
    end

    pls_cell #(
      .ELEM_WIDTH (ELEM_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .new_val   (new_val),
      .left_val  (left_val),
      .right_val (right_val),
      .val       (cell_val[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r     <= st;
      read_value_r <= rd64[31:0];
      length       <= 6'(count_next);
    end
  end

  assign status     = status_r;
  assign read_value = read_value_r;

endmodule

### hw/rtl/pls_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list chain
// Holds one entry; loads a new element or the entry of either neighbor.
// ----------------------------------------------------------------------------
module pls_cell #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic                    clk,
  input  pls_pkg::cell_cmd_t      cmd,
  input  logic [ELEM_WIDTH-1:0]   new_val,
  input  logic [ELEM_WIDTH-1:0]   left_val,
  input  logic [ELEM_WIDTH-1:0]   right_val,
  output logic [ELEM_WIDTH-1:0]   val
);
  import pls_pkg::*;

  logic [ELEM_WIDTH-1:0] val_next;

  // select the source for this cell
  always_comb begin
    case (cmd)
      CELL_HOLD:       val_next = val;
      CELL_LOAD_NEW:   val_next = new_val;
      CELL_TAKE_LEFT:  val_next = left_val;
      CELL_TAKE_RIGHT: val_next = right_val;
      default:         val_next = val;
    endcase
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
